// File: design/esd_pkg.sv
// Shared constants and the command type of the escape sequence decoder.
`default_nettype none
package esd_pkg;

  // Longest hex escape accepted after backslash-u.
  localparam int MAX_HEX_DIGITS = 6;
  localparam int MIN_HEX_DIGITS = 4;
  localparam int BUF_DEPTH      = MAX_HEX_DIGITS - 1;
  localparam int MAX_OUT        = MAX_HEX_DIGITS + 1;
  localparam int CNT_W          = $clog2(MAX_OUT + 1);
  localparam int IDX_W          = $clog2(MAX_OUT);
  localparam int DIG_W          = $clog2(MAX_HEX_DIGITS);
  localparam int BUF_IDX_W      = $clog2(BUF_DEPTH);

  // Code point arithmetic.
  localparam int VAL_W = 21;
  localparam logic [VAL_W-1:0] VALUE_LIMIT = 21'h10FFFF;
  localparam logic [VAL_W-1:0] VALUE_SAT   = 21'h110000;
  localparam logic [VAL_W-1:0] BMP_LIMIT   = 21'h00FFFF;
  localparam logic [VAL_W-1:0] PLANE_BASE  = 21'h010000;
  localparam logic [15:0]      HIGH_SURR   = 16'hD800;
  localparam logic [15:0]      LOW_SURR    = 16'hDC00;

  // Characters that steer the parser.
  localparam logic [15:0] CH_BACKSLASH = 16'h005C;
  localparam logic [15:0] CH_U         = 16'h0075;
  localparam logic [15:0] CH_T         = 16'h0074;
  localparam logic [15:0] CH_N         = 16'h006E;
  localparam logic [15:0] CH_R         = 16'h0072;
  localparam logic [15:0] CH_F         = 16'h0066;
  localparam logic [15:0] CH_V         = 16'h0076;
  localparam logic [15:0] CH_A         = 16'h0061;
  localparam logic [15:0] CC_TAB       = 16'h0009;
  localparam logic [15:0] CC_LF        = 16'h000A;
  localparam logic [15:0] CC_CR        = 16'h000D;
  localparam logic [15:0] CC_FF        = 16'h000C;
  localparam logic [15:0] CC_VT        = 16'h000B;
  localparam logic [15:0] CC_BEL       = 16'h0007;

  // One decoded request: the units it produces, oldest in slot 0.
  typedef struct packed {
    logic [MAX_OUT-1:0][15:0] units;
    logic [CNT_W-1:0]         count;
    logic                     str_last;
  } cmd_t;

endpackage
`default_nettype wire

// File: design/escape_sequence_decoder.sv
// Top level of the streaming backslash escape decoder for UTF-16 text.
//
//   Channel   Handshake          Payload
//   input     push / full        code_unit[15:0], final_unit
//   result    empty / pop        out_unit[15:0], run_last, string_end
//
// Each accepted request is parsed in the cycle it arrives; the parser keeps the
// escape state and the held hex digits and emits a list of up to seven units.
// A request that only opens an escape or adds a held hex digit queues nothing.
// Lists wait in a two-entry queue and the sequencer sends one unit per cycle
// while pop keeps up, so plain text streams at one unit per cycle and a failed
// hex escape replays up to seven units on the output side.
// A result passes from the queue through the output register to the outputs.
// rst is synchronous and returns the parser to normal mode and empties the queue.
// full rises only when both queue entries are occupied; a stalled pop holds the
// current result steady while the parser keeps taking input until the queue fills.
`default_nettype none
module escape_sequence_decoder import esd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] code_unit,
  input  wire logic        final_unit,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_unit,
  output logic             run_last,
  output logic             string_end
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic head_valid;
  cmd_t head;
  logic head_pop;

  // A request is taken whenever the queue has a free entry.
  assign accept = push && !full;

  esd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .code_unit  (code_unit),
    .final_unit (final_unit),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  esd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cmd_valid),
    .wr_data    (cmd),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (full)
  );

  esd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_unit   (out_unit),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule
`default_nettype wire

// File: design/esd_front.sv
// Parser front end: tracks escape state and turns each request into a unit list.
`default_nettype none
module esd_front import esd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [15:0] code_unit,
  input  wire logic        final_unit,
  output logic             cmd_valid,
  output cmd_t             cmd
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  logic [1:0]       mode, mode_next;
  logic [DIG_W-1:0] digit_count, digit_count_next;
  logic [VAL_W-1:0] hex_value, hex_value_next;
  logic [15:0]      digit_buffer [BUF_DEPTH];
  logic             store_digit;

  logic             is_hex;
  logic [3:0]       hex_nibble;
  logic [VAL_W+3:0] nv_wide;
  logic [VAL_W-1:0] nv_sat;

  logic             resolve, res_ok, has_tail;
  logic [VAL_W-1:0] res_val;
  logic [15:0]      tail_unit;
  logic [19:0]      plane_off;
  logic [15:0]      ok_list [2];
  logic [15:0]      fail_list [MAX_OUT];
  logic [CNT_W-1:0] prefix_len;

  always_comb begin
    is_hex     = 1'b1;
    hex_nibble = 4'd0;
    if (code_unit >= 16'h0030 && code_unit <= 16'h0039) begin
      hex_nibble = code_unit[3:0];
    end else if ((code_unit >= 16'h0061 && code_unit <= 16'h0066) ||
                 (code_unit >= 16'h0041 && code_unit <= 16'h0046)) begin
      hex_nibble = code_unit[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // The stored value saturates just above the legal range.
  assign nv_wide = {hex_value, 4'b0000} + {{VAL_W{1'b0}}, hex_nibble};
  assign nv_sat  = (nv_wide > {4'b0000, VALUE_LIMIT}) ? VALUE_SAT : nv_wide[VAL_W-1:0];

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    hex_value_next   = hex_value;
    store_digit      = 1'b0;
    resolve          = 1'b0;
    res_ok           = 1'b0;
    res_val          = hex_value;
    has_tail         = 1'b0;
    tail_unit        = code_unit;
    unique case (mode)
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        has_tail  = 1'b1;
        case (code_unit)
          CH_T:    tail_unit = CC_TAB;
          CH_N:    tail_unit = CC_LF;
          CH_R:    tail_unit = CC_CR;
          CH_F:    tail_unit = CC_FF;
          CH_V:    tail_unit = CC_VT;
          CH_A:    tail_unit = CC_BEL;
          CH_U: begin
            // An escape cut off by the string end replays the u alone.
            has_tail         = final_unit;
            mode_next        = MODE_HEX;
            digit_count_next = '0;
            hex_value_next   = '0;
          end
          default: tail_unit = code_unit;
        endcase
      end
      MODE_HEX: begin
        if (is_hex) begin
          if (digit_count == DIG_W'(MAX_HEX_DIGITS - 1)) begin
            resolve  = 1'b1;
            res_ok   = (nv_sat <= VALUE_LIMIT);
            res_val  = nv_sat;
            has_tail = !res_ok;
          end else if (final_unit) begin
            resolve  = 1'b1;
            res_ok   = (digit_count >= DIG_W'(MIN_HEX_DIGITS - 1)) && (nv_sat <= VALUE_LIMIT);
            res_val  = nv_sat;
            has_tail = !res_ok;
          end else begin
            store_digit      = 1'b1;
            digit_count_next = digit_count + 1'b1;
            hex_value_next   = nv_sat;
          end
        end else begin
          resolve  = 1'b1;
          res_ok   = (digit_count >= DIG_W'(MIN_HEX_DIGITS)) && (hex_value <= VALUE_LIMIT);
          res_val  = hex_value;
          has_tail = (code_unit != CH_BACKSLASH) || final_unit;
        end
        if (resolve) begin
          mode_next        = has_tail || !(code_unit == CH_BACKSLASH && !is_hex) ?
                             MODE_NORMAL : MODE_ESCAPE;
          digit_count_next = '0;
          hex_value_next   = '0;
        end
      end
      default: begin
        has_tail  = (code_unit != CH_BACKSLASH) || final_unit;
        mode_next = has_tail ? MODE_NORMAL : MODE_ESCAPE;
      end
    endcase
    if (final_unit) begin
      mode_next        = MODE_NORMAL;
      digit_count_next = '0;
      hex_value_next   = '0;
    end
  end

  // Resolved escape: one unit, a surrogate pair, or a literal replay.
  assign plane_off = 20'(res_val - PLANE_BASE);

  always_comb begin
    if (res_val > BMP_LIMIT) begin
      ok_list[0] = HIGH_SURR + {6'd0, plane_off[19:10]};
      ok_list[1] = LOW_SURR + {6'd0, plane_off[9:0]};
    end else begin
      ok_list[0] = res_val[15:0];
      ok_list[1] = res_val[15:0];
    end
    fail_list[0] = CH_U;
    for (int j = 0; j < BUF_DEPTH; j++) begin
      fail_list[j+1] = digit_buffer[j];
    end
    fail_list[MAX_OUT-1] = code_unit;
    if (!resolve) begin
      prefix_len = '0;
    end else if (res_ok) begin
      prefix_len = (res_val > BMP_LIMIT) ? CNT_W'(2) : CNT_W'(1);
    end else begin
      prefix_len = CNT_W'(digit_count) + CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_OUT; i++) begin
      if (CNT_W'(i) < prefix_len) begin
        if (res_ok) begin
          cmd.units[i] = (i == 0) ? ok_list[0] : ok_list[1];
        end else begin
          cmd.units[i] = fail_list[i];
        end
      end else begin
        cmd.units[i] = tail_unit;
      end
    end
    cmd.count    = prefix_len + CNT_W'(has_tail);
    cmd.str_last = final_unit;
    cmd_valid    = in_valid && (cmd.count != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      digit_count <= '0;
      hex_value   <= '0;
    end else if (in_valid) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      hex_value   <= hex_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && store_digit) begin
      digit_buffer[digit_count[BUF_IDX_W-1:0]] <= code_unit;
    end
  end

endmodule
`default_nettype wire

// File: design/esd_fifo.sv
// Two-entry command queue between the parser and the output sequencer.
`default_nettype none
module esd_fifo import esd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  input  wire logic rd_en,
  output logic      head_valid,
  output cmd_t      head,
  output logic      full
);

  logic second_valid;
  cmd_t second;

  assign full = second_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid   <= 1'b0;
      second_valid <= 1'b0;
    end else if (rd_en) begin
      head_valid   <= second_valid || wr_en;
      second_valid <= second_valid && wr_en;
    end else if (wr_en) begin
      head_valid   <= 1'b1;
      second_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      head <= second_valid ? second : wr_data;
      if (second_valid) begin
        second <= wr_data;
      end
    end else if (wr_en) begin
      if (head_valid) begin
        second <= wr_data;
      end else begin
        head <= wr_data;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/esd_back.sv
// Output sequencer: walks each command into out_unit, one unit per cycle if pop keeps up.
`default_nettype none
module esd_back import esd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire cmd_t        head,
  output logic             head_pop,
  input  wire logic        pop,
  output logic             empty,
  output logic [15:0]      out_unit,
  output logic             run_last,
  output logic             string_end
);

  logic             out_valid;
  logic [IDX_W-1:0] idx;
  logic             load, at_last;

  assign empty    = !out_valid;
  assign load     = head_valid && (!out_valid || pop);
  assign at_last  = (CNT_W'(idx) + CNT_W'(1)) == head.count;
  assign head_pop = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_unit   <= head.units[idx];
      run_last   <= at_last;
      string_end <= at_last && head.str_last;
    end
  end

endmodule
`default_nettype wire
